FILE: hdl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated by reset.
`define VPA_CHK_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("vpa check failed");

// Next-cycle implication, gated by reset.
`define VPA_CHK_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("vpa check failed");

`endif

FILE: hdl/vpa_pkg.sv
package vpa_pkg;

  localparam int unsigned FREE_ENTRIES  = 16;
  localparam int unsigned OWNER_ENTRIES = 16;
  localparam int unsigned ADDRESS_BITS  = 16;

  localparam int unsigned FI_W   = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;
  localparam int unsigned OI_W   = (OWNER_ENTRIES > 1) ? $clog2(OWNER_ENTRIES) : 1;
  localparam int unsigned SCAN_N = (FREE_ENTRIES > OWNER_ENTRIES) ? FREE_ENTRIES
                                                                 : OWNER_ENTRIES;
  localparam int unsigned CNT_W  = $clog2(SCAN_N);

  localparam longint unsigned ADDR_MAX = (64'd1 << ADDRESS_BITS) - 64'd1;

  localparam logic [15:0] DEF_MEM_SIZE = 16'd1024;
  localparam logic [15:0] DEF_MIN_FRAG = 16'd10;

  typedef enum logic {CMD_ALLOC = 1'b0, CMD_FREE = 1'b1} cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_UNKNOWN = 3'd2,
    ST_ZERO    = 3'd3,
    ST_FULL    = 3'd4,
    ST_HOLDS   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2,
    POL_RSVD  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    CFG_MEM_SIZE = 2'd0,
    CFG_POLICY   = 2'd1,
    CFG_MIN_FRAG = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {S_INIT, S_IDLE, S_SCAN, S_FSCAN, S_APPLY} state_e;

  typedef struct packed {
    logic        command;
    logic [7:0]  owner_id;
    logic [15:0] request_size;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] start_address;
    logic [15:0] granted_size;
  } out_item_t;

  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
  } free_ent_t;

  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] start;
    logic [15:0] size;
  } own_ent_t;

  typedef struct packed {
    policy_e     policy;
    logic [15:0] min_frag;
  } cfg_t;

  typedef struct packed {
    logic        load;
    logic [15:0] size;
  } reload_t;

  function automatic logic [15:0] clip_size(logic [15:0] v);
    if (64'(v) > ADDR_MAX) return 16'(ADDR_MAX);
    return v;
  endfunction

  // Candidate c beats current pick b; ties fall to the lower start.
  function automatic logic better_fit(policy_e p, free_ent_t c, free_ent_t b);
    if (p == POL_BEST && c.size != b.size) return c.size < b.size;
    if (p == POL_WORST && c.size != b.size) return c.size > b.size;
    return c.start < b.start;
  endfunction

endpackage

FILE: hdl/vpa_ram.sv
module vpa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/vpa_core.sv
module vpa_core import vpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  reload_t   reload_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output out_item_t res_data_o
);

  state_e state_q, state_d;
  in_item_t item_q, item_d;

  logic [CNT_W-1:0] cnt_q, cnt_d, ridx_q, ridx_d, last_idx;
  logic iss_done_q, iss_done_d, rdv_q, rdv_d;
  logic scan_act, issue, scan_end, enter_scan, own_in, free_in, fvld;

  logic [FREE_ENTRIES-1:0]  fvld_q, fvld_d;
  logic [OWNER_ENTRIES-1:0] ovld_q, ovld_d;

  // Scan results
  logic ofound_q, ofound_d, slot_found_q, slot_found_d, pick_q, pick_d;
  logic [OI_W-1:0] oidx_q, oidx_d, slot_q, slot_d;
  logic [15:0] os_q, os_d, on_q, on_d;
  logic [FI_W-1:0] pidx_q, pidx_d;
  free_ent_t best_q, best_d;
  logic left_q, left_d, right_q, right_d, empty_q, empty_d;
  logic [FI_W-1:0] lidx_q, lidx_d, ridx2_q, ridx2_d, eidx_q, eidx_d;
  logic [15:0] lstart_q, lstart_d, lsize_q, lsize_d, rsize_q, rsize_d;

  // RAM ports
  logic f_we, o_we;
  logic [FI_W-1:0] f_waddr;
  logic [OI_W-1:0] o_waddr;
  free_ent_t f_wdata, f_rdata;
  own_ent_t  o_wdata, o_rdata;

  logic [15:0] rest, grant, reload_sz;
  logic absorb, go;
  status_e status;

  vpa_ram #(.WIDTH($bits(free_ent_t)), .DEPTH(FREE_ENTRIES)) u_free_ram (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .raddr_i(cnt_q[FI_W-1:0]),
    .rdata_o(f_rdata)
  );

  vpa_ram #(.WIDTH($bits(own_ent_t)), .DEPTH(OWNER_ENTRIES)) u_own_ram (
    .clk_i  (clk_i),
    .we_i   (o_we),
    .waddr_i(o_waddr),
    .wdata_i(o_wdata),
    .raddr_i(cnt_q[OI_W-1:0]),
    .rdata_o(o_rdata)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign scan_act   = (state_q == S_SCAN) || (state_q == S_FSCAN);
  assign issue      = scan_act && !iss_done_q;
  assign scan_end   = rdv_q && (ridx_q == last_idx);
  assign own_in     = 32'(ridx_q) < OWNER_ENTRIES;
  assign free_in    = 32'(ridx_q) < FREE_ENTRIES;
  assign fvld       = fvld_q[ridx_q[FI_W-1:0]];

  always_comb begin
    if (state_q == S_FSCAN) begin
      last_idx = CNT_W'(FREE_ENTRIES - 1);
    end else if (item_q.command == CMD_ALLOC) begin
      last_idx = CNT_W'(SCAN_N - 1);
    end else begin
      last_idx = CNT_W'(OWNER_ENTRIES - 1);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT:  state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_d = (item_q.command == CMD_FREE && ofound_d) ? S_FSCAN : S_APPLY;
        end
      end
      S_FSCAN: if (scan_end) state_d = S_APPLY;
      S_APPLY: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign enter_scan = (state_d != state_q) &&
                      ((state_d == S_SCAN) || (state_d == S_FSCAN));

  // Scan sequencing and per-entry evaluation
  always_comb begin
    item_d       = item_q;
    cnt_d        = cnt_q;
    iss_done_d   = iss_done_q;
    rdv_d        = issue;
    ridx_d       = cnt_q;
    ofound_d     = ofound_q;
    slot_found_d = slot_found_q;
    pick_d       = pick_q;
    oidx_d       = oidx_q;
    slot_d       = slot_q;
    os_d         = os_q;
    on_d         = on_q;
    pidx_d       = pidx_q;
    best_d       = best_q;
    left_d       = left_q;
    right_d      = right_q;
    empty_d      = empty_q;
    lidx_d       = lidx_q;
    ridx2_d      = ridx2_q;
    eidx_d       = eidx_q;
    lstart_d     = lstart_q;
    lsize_d      = lsize_q;
    rsize_d      = rsize_q;

    if (issue) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == last_idx) iss_done_d = 1'b1;
    end

    if (rdv_q) begin
      if (state_q == S_SCAN) begin
        if (own_in) begin
          if (ovld_q[ridx_q[OI_W-1:0]]) begin
            if (o_rdata.owner == item_q.owner_id && !ofound_q) begin
              ofound_d = 1'b1;
              oidx_d   = ridx_q[OI_W-1:0];
              os_d     = o_rdata.start;
              on_d     = o_rdata.size;
            end
          end else if (!slot_found_q) begin
            slot_found_d = 1'b1;
            slot_d       = ridx_q[OI_W-1:0];
          end
        end
        if (item_q.command == CMD_ALLOC && free_in && fvld &&
            f_rdata.size >= item_q.request_size &&
            (!pick_q || better_fit(cfg_i.policy, f_rdata, best_q))) begin
          pick_d = 1'b1;
          pidx_d = ridx_q[FI_W-1:0];
          best_d = f_rdata;
        end
      end else if (state_q == S_FSCAN) begin
        if (!fvld) begin
          if (!empty_q) begin
            empty_d = 1'b1;
            eidx_d  = ridx_q[FI_W-1:0];
          end
        end else if ((17'(f_rdata.start) + 17'(f_rdata.size)) == 17'(os_q) && !left_q) begin
          left_d   = 1'b1;
          lidx_d   = ridx_q[FI_W-1:0];
          lstart_d = f_rdata.start;
          lsize_d  = f_rdata.size;
        end else if (17'(f_rdata.start) == (17'(os_q) + 17'(on_q)) && !right_q) begin
          right_d = 1'b1;
          ridx2_d = ridx_q[FI_W-1:0];
          rsize_d = f_rdata.size;
        end
      end
    end

    if (state_q == S_IDLE && in_valid_i) begin
      item_d       = in_data_i;
      ofound_d     = 1'b0;
      slot_found_d = 1'b0;
      pick_d       = 1'b0;
    end
    if (state_q == S_SCAN) begin
      left_d  = 1'b0;
      right_d = 1'b0;
      empty_d = 1'b0;
    end
    if (enter_scan) begin
      cnt_d      = '0;
      iss_done_d = 1'b0;
      rdv_d      = 1'b0;
    end
  end

  // Result and table updates
  assign rest   = best_q.size - item_q.request_size;
  assign absorb = (rest < cfg_i.min_frag) || (rest == 16'd0);
  assign grant  = absorb ? best_q.size : item_q.request_size;
  assign go     = (state_q == S_APPLY) && res_ready_i;
  assign reload_sz = clip_size(reload_i.size);

  always_comb begin
    if (item_q.command == CMD_ALLOC) begin
      if (item_q.request_size == 16'd0) status = ST_ZERO;
      else if (ofound_q)                status = ST_HOLDS;
      else if (!slot_found_q)           status = ST_FULL;
      else if (!pick_q)                 status = ST_NOFIT;
      else                              status = ST_OK;
    end else begin
      if (!ofound_q)                          status = ST_UNKNOWN;
      else if (!left_q && !right_q && !empty_q) status = ST_FULL;
      else                                    status = ST_OK;
    end
  end

  always_comb begin
    res_valid_o = (state_q == S_APPLY);
    res_data_o.status        = status;
    res_data_o.start_address = 16'd0;
    res_data_o.granted_size  = 16'd0;
    if (status == ST_OK) begin
      if (item_q.command == CMD_ALLOC) begin
        res_data_o.start_address = best_q.start;
        res_data_o.granted_size  = grant;
      end else begin
        res_data_o.start_address = os_q;
        res_data_o.granted_size  = on_q;
      end
    end

    f_we    = 1'b0;
    f_waddr = pidx_q;
    f_wdata = '{start: best_q.start + item_q.request_size, size: rest};
    o_we    = 1'b0;
    o_waddr = slot_q;
    o_wdata = '{owner: item_q.owner_id, start: best_q.start, size: grant};
    fvld_d  = fvld_q;
    ovld_d  = ovld_q;

    if (reload_i.load) begin
      f_we    = 1'b1;
      f_waddr = '0;
      f_wdata = '{start: 16'd0, size: reload_sz};
      fvld_d  = '0;
      fvld_d[0] = (reload_sz != 16'd0);
      ovld_d  = '0;
    end else if (state_q == S_INIT) begin
      f_we    = 1'b1;
      f_waddr = '0;
      f_wdata = '{start: 16'd0, size: clip_size(DEF_MEM_SIZE)};
    end else if (go && status == ST_OK) begin
      if (item_q.command == CMD_ALLOC) begin
        if (absorb) fvld_d[pidx_q] = 1'b0;
        else        f_we = 1'b1;
        o_we           = 1'b1;
        ovld_d[slot_q] = 1'b1;
      end else begin
        f_we = 1'b1;
        if (left_q) begin
          f_waddr = lidx_q;
          f_wdata = '{start: lstart_q,
                      size: lsize_q + on_q + (right_q ? rsize_q : 16'd0)};
          if (right_q) fvld_d[ridx2_q] = 1'b0;
        end else if (right_q) begin
          f_waddr = ridx2_q;
          f_wdata = '{start: os_q, size: rsize_q + on_q};
        end else begin
          f_waddr = eidx_q;
          f_wdata = '{start: os_q, size: on_q};
          fvld_d[eidx_q] = 1'b1;
        end
        ovld_d[oidx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      cnt_q        <= '0;
      iss_done_q   <= 1'b0;
      rdv_q        <= 1'b0;
      fvld_q       <= FREE_ENTRIES'((clip_size(DEF_MEM_SIZE) != 16'd0) ? 1 : 0);
      ovld_q       <= '0;
      ofound_q     <= 1'b0;
      slot_found_q <= 1'b0;
      pick_q       <= 1'b0;
      left_q       <= 1'b0;
      right_q      <= 1'b0;
      empty_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      iss_done_q   <= iss_done_d;
      rdv_q        <= rdv_d;
      fvld_q       <= fvld_d;
      ovld_q       <= ovld_d;
      ofound_q     <= ofound_d;
      slot_found_q <= slot_found_d;
      pick_q       <= pick_d;
      left_q       <= left_d;
      right_q      <= right_d;
      empty_q      <= empty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    ridx_q   <= ridx_d;
    oidx_q   <= oidx_d;
    slot_q   <= slot_d;
    os_q     <= os_d;
    on_q     <= on_d;
    pidx_q   <= pidx_d;
    best_q   <= best_d;
    lidx_q   <= lidx_d;
    ridx2_q  <= ridx2_d;
    eidx_q   <= eidx_d;
    lstart_q <= lstart_d;
    lsize_q  <= lsize_d;
    rsize_q  <= rsize_d;
  end

endmodule

FILE: hdl/variable_partition_allocator.sv
// Variable partition allocator: free-region and owner tables over one memory.
// Input channel (in_valid_i / in_stall_o / in_data_i): one request per
// transfer, allocate (owner, size) or free (owner). Output channel
// (out_valid_o / out_stall_i / out_data_o): exactly one result per request.
// Config port: cfg_we_i writes register cfg_idx_i (0 memory size, 1 fit
// policy, 2 minimum fragment); a memory size write reloads both tables.
// Scanning: an allocate scans both tables in one pass through their RAMs,
// one entry per cycle. A free scans the owner table, then, if the owner
// is found, the free table.
// The rate is set by those table scans over the single read port of each
// RAM; one request is in work at a time.
// Reset: tables hold one free region [0,1024), owner table empty; the first
// cycle after reset writes that region into the free RAM with input stalled.
// The result sits in an output register, so a stalled receiver holds back the
// next result; the next request is still taken and scanned meanwhile.
module variable_partition_allocator import vpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  reload_t   reload;
  logic      res_valid, res_ready;
  out_item_t res_data;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q, out_data_d;

  // Config registers; a memory size write is not stored but kicks a table reload
  always_comb begin
    cfg_d       = cfg_q;
    reload.load = 1'b0;
    reload.size = cfg_data_i;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MEM_SIZE: reload.load   = 1'b1;
        CFG_POLICY:   cfg_d.policy   = policy_e'(cfg_data_i[1:0]);
        CFG_MIN_FRAG: cfg_d.min_frag = cfg_data_i;
        default: ;
      endcase
    end
  end

  vpa_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .reload_i   (reload),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_data_o (res_data)
  );

  // Output register: free, or emptied by a transfer this cycle
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '{policy: POL_FIRST, min_frag: DEF_MIN_FRAG};
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hdl/vpa_checker.sv
`include "assert_macros.svh"

module vpa_checker import vpa_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  logic res_err, res_ok, res_zero;

  assign res_err  = out_valid_o && (out_data_o.status != ST_OK);
  assign res_ok   = out_valid_o && (out_data_o.status == ST_OK);
  assign res_zero = (out_data_o.start_address == 16'd0) && (out_data_o.granted_size == 16'd0);

  `VPA_CHK_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `VPA_CHK_SAME(a_err_zero, res_err, res_zero)
  `VPA_CHK_SAME(a_ok_size, res_ok, out_data_o.granted_size != 16'd0)
  `VPA_CHK_SAME(a_init_stall, !$past(rst_ni), in_stall_o)

endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
